// ===== hw/rtl/mnfs_pkg.sv =====
// Shared constants and control structs for the minimax nearest-feature selector.
`timescale 1ns / 1ps

package mnfs_pkg;

   localparam int MAX_BLOCKS_DEF   = 256;
   localparam int NUM_FEATURES_DEF = 16;

   localparam int FEATURE_W   = 16;
   localparam int INDEX_W     = 8;
   localparam int DISTANCE_W  = 8;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   localparam logic CSR_REQUIRED_MASK = 1'b0;

   typedef struct packed {
      logic load;        // store one block beat
      logic last;        // this beat closes the row
      logic pass_start;  // clear scan state before a pass
      logic issue;       // read one row entry
      logic bwd;         // entry belongs to the backward pass
      logic first;       // first required feature: old scores count as zero
      logic emit;        // present the result
      logic found;       // every required feature was present
      logic use_best;    // at least one feature was folded in
   } mnfs_cmd_type;

   typedef struct packed {
      logic seen;        // feature present somewhere in the row
   } mnfs_status_type;

endpackage

// ===== hw/rtl/mnfs_ctrl.sv =====
// Sequencer: walks the features and drives forward and backward passes over the row.
`timescale 1ns / 1ps

module mnfs_ctrl #(
   parameter int MAX_BLOCKS   = mnfs_pkg::MAX_BLOCKS_DEF,
   parameter int NUM_FEATURES = mnfs_pkg::NUM_FEATURES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic                                  last_block,
   input  logic [mnfs_pkg::FEATURE_W-1:0]        required_mask,
   input  logic [$clog2(MAX_BLOCKS+1)-1:0]       row_len,
   input  mnfs_pkg::mnfs_status_type             status,
   output mnfs_pkg::mnfs_cmd_type                cmd,
   output logic [((MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1)-1:0] rd_addr,
   output logic [((((NUM_FEATURES < mnfs_pkg::FEATURE_W) ? NUM_FEATURES
                    : mnfs_pkg::FEATURE_W) > 1)
                  ? $clog2((NUM_FEATURES < mnfs_pkg::FEATURE_W) ? NUM_FEATURES
                           : mnfs_pkg::FEATURE_W) : 1)-1:0] feat,
   output logic                                  busy
);

   localparam int AW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int EFF = (NUM_FEATURES < mnfs_pkg::FEATURE_W) ? NUM_FEATURES
                        : mnfs_pkg::FEATURE_W;
   localparam int KW  = (EFF > 1) ? $clog2(EFF) : 1;

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_FEAT    = 7'b0000010,
      S_FWD     = 7'b0000100,
      S_FWD_END = 7'b0001000,
      S_CHK     = 7'b0010000,
      S_BWD     = 7'b0100000,
      S_BWD_END = 7'b1000000
   } state_type;

   state_type       state_ff, state_in;
   logic [KW-1:0]   k_ff, k_in;
   logic [AW-1:0]   addr_ff, addr_in;
   logic            any_ff, any_in;
   logic            found_ff, found_in;
   logic            done_ff, done_in;
   logic [AW-1:0]   last_addr;
   logic            k_last;

   assign last_addr = AW'(row_len - 1'b1);
   assign k_last    = (k_ff == KW'(EFF - 1));
   assign rd_addr   = addr_ff;
   assign feat      = k_ff;
   assign busy      = (state_ff != S_IDLE) || done_ff;

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      addr_in  = addr_ff;
      any_in   = any_ff;
      found_in = found_ff;
      done_in  = 1'b0;
      cmd      = '0;
      cmd.first    = !any_ff;
      cmd.found    = found_ff;
      cmd.use_best = any_ff;
      cmd.emit     = done_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start && !done_ff) begin
               cmd.load = 1'b1;
               cmd.last = last_block;
               if (last_block) begin
                  k_in     = '0;
                  any_in   = 1'b0;
                  state_in = S_FEAT;
               end
            end
         end
         S_FEAT: begin
            if (required_mask[k_ff]) begin
               cmd.pass_start = 1'b1;
               addr_in        = '0;
               state_in       = S_FWD;
            end else if (k_last) begin
               found_in = 1'b1;
               done_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_FWD: begin
            cmd.issue = 1'b1;
            if (addr_ff == last_addr) begin
               state_in = S_FWD_END;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         S_FWD_END: begin
            state_in = S_CHK;
         end
         S_CHK: begin
            // drop the search when the feature is absent from the row
            if (!status.seen) begin
               found_in = 1'b0;
               done_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.pass_start = 1'b1;
               addr_in        = last_addr;
               state_in       = S_BWD;
            end
         end
         S_BWD: begin
            cmd.issue = 1'b1;
            cmd.bwd   = 1'b1;
            if (addr_ff == '0) begin
               state_in = S_BWD_END;
            end else begin
               addr_in = addr_ff - 1'b1;
            end
         end
         S_BWD_END: begin
            any_in = 1'b1;
            if (k_last) begin
               found_in = 1'b1;
               done_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_FEAT;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         k_ff     <= '0;
         addr_ff  <= '0;
         any_ff   <= 1'b0;
         found_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         addr_ff  <= addr_in;
         any_ff   <= any_in;
         found_ff <= found_in;
         done_ff  <= done_in;
      end
   end

endmodule

// ===== hw/rtl/mnfs_datapath.sv =====
// Datapath: block store, distance and score memories, scan pipeline and result register.
`timescale 1ns / 1ps

module mnfs_datapath #(
   parameter int MAX_BLOCKS   = mnfs_pkg::MAX_BLOCKS_DEF,
   parameter int NUM_FEATURES = mnfs_pkg::NUM_FEATURES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mnfs_pkg::mnfs_cmd_type                cmd,
   input  logic [((MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1)-1:0] rd_addr,
   input  logic [((((NUM_FEATURES < mnfs_pkg::FEATURE_W) ? NUM_FEATURES
                   : mnfs_pkg::FEATURE_W) > 1)
                 ? $clog2((NUM_FEATURES < mnfs_pkg::FEATURE_W) ? NUM_FEATURES
                          : mnfs_pkg::FEATURE_W) : 1)-1:0] feat,
   input  logic [mnfs_pkg::FEATURE_W-1:0]        feature_mask,
   output logic [$clog2(MAX_BLOCKS+1)-1:0]       row_len,
   output mnfs_pkg::mnfs_status_type             status,
   output logic                                  rsp_valid,
   output logic [mnfs_pkg::INDEX_W-1:0]          rsp_best_index,
   output logic [mnfs_pkg::DISTANCE_W-1:0]       rsp_best_distance,
   output logic                                  rsp_found
);

   localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int EFF = (NUM_FEATURES < mnfs_pkg::FEATURE_W) ? NUM_FEATURES
                        : mnfs_pkg::FEATURE_W;
   localparam int KW  = (EFF > 1) ? $clog2(EFF) : 1;

   logic [mnfs_pkg::FEATURE_W-1:0] store_mem [MAX_BLOCKS];
   logic [AW:0]                    near_mem  [MAX_BLOCKS];   // {no_left_hit, distance}
   logic [AW-1:0]                  score_mem [MAX_BLOCKS];

   logic [CW-1:0]                  count_ff, count_in;
   logic [CW-1:0]                  row_len_ff;
   logic                           room;

   logic [mnfs_pkg::FEATURE_W-1:0] store_q_ff;
   logic [AW:0]                    near_q_ff;
   logic [AW-1:0]                  score_q_ff;
   logic                           stage_valid_ff;
   logic                           stage_bwd_ff;
   logic [AW-1:0]                  stage_addr_ff;

   logic                           seen_ff, seen_in;
   logic [AW-1:0]                  pos_ff, pos_in;
   logic                           best_valid_ff;
   logic [AW-1:0]                  best_score_ff;
   logic [AW-1:0]                  best_idx_ff;

   logic                           hit;
   logic [AW-1:0]                  fwd_dist;
   logic [AW-1:0]                  bwd_dist;
   logic [AW-1:0]                  cand;
   logic [AW-1:0]                  old_score;
   logic [AW-1:0]                  new_score;
   logic [KW-1:0]                  feat_sel;

   logic                           rsp_valid_ff;
   logic [mnfs_pkg::INDEX_W-1:0]   rsp_index_ff;
   logic [mnfs_pkg::DISTANCE_W-1:0] rsp_dist_ff;
   logic                           rsp_found_ff;
   logic [31:0]                    best_score_ext;
   logic [31:0]                    best_idx_ext;

   assign room     = (count_ff < CW'(MAX_BLOCKS));
   assign count_in = room ? count_ff + 1'b1 : count_ff;
   assign row_len  = row_len_ff;
   assign feat_sel = feat;

   // row loading
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         row_len_ff <= '0;
      end else if (cmd.load) begin
         if (cmd.last) begin
            row_len_ff <= count_in;
            count_ff   <= '0;
         end else begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && room) begin
         store_mem[count_ff[AW-1:0]] <= feature_mask;
      end
      store_q_ff <= store_mem[rd_addr];
   end

   // scan stage, in the cycle after the read
   assign hit      = store_q_ff[feat_sel];
   assign seen_in  = seen_ff | hit;
   assign pos_in   = hit ? stage_addr_ff : pos_ff;
   assign fwd_dist = stage_addr_ff - pos_in;
   assign bwd_dist = pos_in - stage_addr_ff;

   always_comb begin
      if (seen_in && (near_q_ff[AW] || (bwd_dist < near_q_ff[AW-1:0]))) begin
         cand = bwd_dist;
      end else begin
         cand = near_q_ff[AW-1:0];
      end
      old_score = cmd.first ? '0 : score_q_ff;
      new_score = (cand > old_score) ? cand : old_score;
   end

   always_ff @(posedge clock) begin
      near_q_ff  <= near_mem[rd_addr];
      score_q_ff <= score_mem[rd_addr];
      if (stage_valid_ff && !stage_bwd_ff) begin
         near_mem[stage_addr_ff] <= seen_in ? {1'b0, fwd_dist} : {1'b1, {AW{1'b0}}};
      end
      if (stage_valid_ff && stage_bwd_ff) begin
         score_mem[stage_addr_ff] <= new_score;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= cmd.issue;
      end
      stage_bwd_ff  <= cmd.bwd;
      stage_addr_ff <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff       <= 1'b0;
         best_valid_ff <= 1'b0;
      end else if (cmd.pass_start) begin
         seen_ff       <= 1'b0;
         best_valid_ff <= 1'b0;
      end else if (stage_valid_ff) begin
         seen_ff <= seen_in;
         // descending pass: ties move the pick to the lower index
         if (stage_bwd_ff && (!best_valid_ff || (new_score <= best_score_ff))) begin
            best_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_valid_ff) begin
         pos_ff <= pos_in;
         if (stage_bwd_ff && (!best_valid_ff || (new_score <= best_score_ff))) begin
            best_score_ff <= new_score;
            best_idx_ff   <= stage_addr_ff;
         end
      end
   end

   assign status.seen = seen_ff;

   // result beat
   assign best_score_ext = 32'(best_score_ff);
   assign best_idx_ext   = 32'(best_idx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
      if (cmd.emit) begin
         rsp_found_ff <= cmd.found;
         if (cmd.found && cmd.use_best) begin
            rsp_index_ff <= best_idx_ext[mnfs_pkg::INDEX_W-1:0];
            rsp_dist_ff  <= (best_score_ext > 32'd255) ? 8'hFF
                            : best_score_ext[mnfs_pkg::DISTANCE_W-1:0];
         end else begin
            rsp_index_ff <= '0;
            rsp_dist_ff  <= '0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_best_index    = rsp_index_ff;
   assign rsp_best_distance = rsp_dist_ff;
   assign rsp_found         = rsp_found_ff;

endmodule

// ===== hw/rtl/minimax_nearest_feature_select_top.sv =====
// Top level: register port, sequencer and datapath of the minimax nearest-feature selector.
`timescale 1ns / 1ps

// Blocks of a row are loaded one per cycle (start high, busy low). The beat with
// req_last_block set ends the row and starts the search; busy then stays high
// until the search ends. The row length is capped at MAX_BLOCKS, and the
// sequencer walks min(NUM_FEATURES,16) features, scanning the required ones; the
// search stops early after the forward pass of a feature that is absent. Each
// required feature costs a forward and a backward scan over the row
// memories. The result shows on the rsp_ ports with rsp_valid for exactly one
// cycle, the first cycle busy is low, and cannot be held off: capture it then.
// required_mask must only be written while busy is low.
module minimax_nearest_feature_select_top #(
   parameter int MAX_BLOCKS   = mnfs_pkg::MAX_BLOCKS_DEF,
   parameter int NUM_FEATURES = mnfs_pkg::NUM_FEATURES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [mnfs_pkg::FEATURE_W-1:0]     req_feature_mask,
   input  logic                               req_last_block,
   output logic                               rsp_valid,
   output logic [mnfs_pkg::INDEX_W-1:0]       rsp_best_index,
   output logic [mnfs_pkg::DISTANCE_W-1:0]    rsp_best_distance,
   output logic                               rsp_found,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [mnfs_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [mnfs_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [mnfs_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready
);

   localparam int AW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW  = $clog2(MAX_BLOCKS + 1);
   localparam int EFF = (NUM_FEATURES < mnfs_pkg::FEATURE_W) ? NUM_FEATURES
                        : mnfs_pkg::FEATURE_W;
   localparam int KW  = (EFF > 1) ? $clog2(EFF) : 1;

   logic [mnfs_pkg::FEATURE_W-1:0] csr_required_mask_ff;
   logic                           csr_write;
   logic                           csr_sel;

   mnfs_pkg::mnfs_cmd_type         cmd;
   mnfs_pkg::mnfs_status_type      status;
   logic [AW-1:0]                  rd_addr;
   logic [KW-1:0]                  feat;
   logic [CW-1:0]                  row_len;

   assign pready    = 1'b1;
   assign csr_sel   = paddr[mnfs_pkg::CSR_ADDR_W-1];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_required_mask_ff <= '0;
      end else if (csr_write && (csr_sel == mnfs_pkg::CSR_REQUIRED_MASK)) begin
         csr_required_mask_ff <= pwdata[mnfs_pkg::FEATURE_W-1:0];
      end
   end

   always_comb begin
      unique case (csr_sel)
         mnfs_pkg::CSR_REQUIRED_MASK: begin
            prdata = mnfs_pkg::CSR_DATA_W'(csr_required_mask_ff);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   mnfs_ctrl #(
      .MAX_BLOCKS   (MAX_BLOCKS),
      .NUM_FEATURES (NUM_FEATURES)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .last_block    (req_last_block),
      .required_mask (csr_required_mask_ff),
      .row_len       (row_len),
      .status        (status),
      .cmd           (cmd),
      .rd_addr       (rd_addr),
      .feat          (feat),
      .busy          (busy)
   );

   mnfs_datapath #(
      .MAX_BLOCKS   (MAX_BLOCKS),
      .NUM_FEATURES (NUM_FEATURES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .rd_addr           (rd_addr),
      .feat              (feat),
      .feature_mask      (req_feature_mask),
      .row_len           (row_len),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_best_index    (rsp_best_index),
      .rsp_best_distance (rsp_best_distance),
      .rsp_found         (rsp_found)
   );

endmodule

// ===== hw/rtl/mnfs_checker.sv =====
// Port-level checks for the minimax nearest-feature selector, bound to the top level.
`timescale 1ns / 1ps

module mnfs_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               req_last_block,
   input logic                               rsp_valid,
   input logic [mnfs_pkg::INDEX_W-1:0]       rsp_best_index,
   input logic [mnfs_pkg::DISTANCE_W-1:0]    rsp_best_distance,
   input logic                               rsp_found
);

   // a closing beat must start the search
   a_last_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_last_block) |=> busy)
      else $error("search did not start after the closing beat");

   // a plain load beat never yields a result
   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_last_block) |=> !rsp_valid)
      else $error("result after a load beat");

   // the result beat comes once the search is over
   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while still busy");

   a_result_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> ((rsp_best_index == '0) && (rsp_best_distance == '0)))
      else $error("not-found result carries nonzero fields");

endmodule

bind minimax_nearest_feature_select_top mnfs_checker u_mnfs_checker (.*);
